@@ rtl/prime_capacity_selector_defines.svh @@
`ifndef PRIME_CAPACITY_SELECTOR_DEFINES_SVH
`define PRIME_CAPACITY_SELECTOR_DEFINES_SVH
// Assertion helpers; define ASSERT_OFF to drop them.
`ifndef ASSERT_OFF
`define PCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PCS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCS_ASSERT(lbl, prop, msg)
`define PCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/pcs_pkg.sv @@
package pcs_pkg;

	localparam int TABLE_SIZE = 72;
	localparam logic [30:0] MAX_PRIME_RST = 31'd2146435069;
	localparam logic [30:0] TOP_31 = 31'h7FFF_FFFF;
	localparam logic [30:0] MIN_CAPACITY = 31'd3;
	localparam logic [30:0] TABLE_LAST = 31'd7199369;

	typedef enum logic [1:0] {
		CMD_TEST   = 2'd0,
		CMD_NEXT   = 2'd1,
		CMD_EXPAND = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LOOKUP,
		ST_SCAN,
		ST_CAND,
		ST_CHECK,
		ST_MODW,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [30:0] value;
	} item_t;

	typedef struct packed {
		logic [30:0] answer;
		logic        capped;
	} result_t;

	// request to the remainder unit
	typedef struct packed {
		logic        start;
		logic [30:0] dividend;
		logic [15:0] divisor;
	} mod_req_t;

	// capacity prime table, growing
	localparam logic [22:0] CAP_PRIMES [TABLE_SIZE] = '{
		23'd3, 23'd7, 23'd11, 23'd17, 23'd23, 23'd29, 23'd37, 23'd47, 23'd59,
		23'd71, 23'd89, 23'd107, 23'd131, 23'd163, 23'd197, 23'd239, 23'd293,
		23'd353, 23'd431, 23'd521, 23'd631, 23'd761, 23'd919, 23'd1103, 23'd1327,
		23'd1597, 23'd1931, 23'd2333, 23'd2801, 23'd3371, 23'd4049, 23'd4861,
		23'd5839, 23'd7013, 23'd8419, 23'd10103, 23'd12143, 23'd14591, 23'd17519,
		23'd21023, 23'd25229, 23'd30293, 23'd36353, 23'd43627, 23'd52361,
		23'd62851, 23'd75431, 23'd90523, 23'd108631, 23'd130363, 23'd156437,
		23'd187751, 23'd225307, 23'd270371, 23'd324449, 23'd389357, 23'd467237,
		23'd560689, 23'd672827, 23'd807403, 23'd968897, 23'd1162687,
		23'd1395263, 23'd1674319, 23'd2009191, 23'd2411033, 23'd2893249,
		23'd3471899, 23'd4166287, 23'd4999559, 23'd5999471, 23'd7199369
	};

endpackage

@@ rtl/prime_capacity_selector.sv @@
// Channel  | Ports                 | Handshake
// ---------+-----------------------+------------------------------------
// item in  | start, busy, item     | word taken when start & !busy
// result   | strobe, result        | word valid for the one strobe cycle
// config   | cfg_we, cfg_data      | max_prime written when cfg_we
//
// One item at a time; busy is high from acceptance through the strobe cycle.
// Table lookups scan the capacity prime table; test and search use trial
// division by odd divisors from 3 upward in the shared remainder unit, one
// divisor at a time, until the divisor squared exceeds the candidate.
// Reset puts the sequencer idle and max_prime to 2146435069.
// The result cannot be stalled; it shows for exactly one cycle.
`include "prime_capacity_selector_defines.svh"

module prime_capacity_selector (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pcs_pkg::item_t   item,
	output logic             strobe,
	output pcs_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [30:0]      cfg_data
);

	pcs_pkg::state_t state_q, state_nx;
	pcs_pkg::cmd_t   cmd_q;
	pcs_pkg::mod_req_t mod_req;

	logic [30:0] max_prime_q;
	logic [30:0] val_q;
	logic [30:0] want_q;
	logic [30:0] cand_q;
	logic [15:0] d_q;
	logic [6:0]  idx_q;
	logic [30:0] ans_q;
	logic        capped_q;

	logic [31:0] dbl;
	logic        cap_hit;
	logic [31:0] sq;
	logic        sq_over;
	logic        mod_done;
	logic [15:0] mod_rem;
	logic [30:0] tab_val;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_prime_q <= pcs_pkg::MAX_PRIME_RST;
		end else if (cfg_we) begin
			max_prime_q <= cfg_data;
		end
	end

	// shared compare terms
	assign dbl     = {val_q, 1'b0};
	assign cap_hit = (dbl > {1'b0, max_prime_q}) && ((max_prime_q > val_q) || dbl[31]);
	assign sq      = d_q * d_q;
	assign sq_over = sq > {1'b0, cand_q};
	assign tab_val = {8'd0, pcs_pkg::CAP_PRIMES[idx_q]};

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			pcs_pkg::ST_IDLE: begin
				if (start) state_nx = pcs_pkg::ST_DISPATCH;
			end
			pcs_pkg::ST_DISPATCH: begin
				unique case (cmd_q)
					pcs_pkg::CMD_TEST: begin
						state_nx = val_q[0] ? pcs_pkg::ST_CHECK : pcs_pkg::ST_OUT;
					end
					pcs_pkg::CMD_NEXT: state_nx = pcs_pkg::ST_LOOKUP;
					pcs_pkg::CMD_EXPAND: begin
						state_nx = cap_hit ? pcs_pkg::ST_OUT : pcs_pkg::ST_LOOKUP;
					end
					default: state_nx = pcs_pkg::ST_OUT;
				endcase
			end
			pcs_pkg::ST_LOOKUP: begin
				priority if (want_q <= pcs_pkg::MIN_CAPACITY) state_nx = pcs_pkg::ST_OUT;
				else if (want_q > pcs_pkg::TABLE_LAST) state_nx = pcs_pkg::ST_CAND;
				else state_nx = pcs_pkg::ST_SCAN;
			end
			pcs_pkg::ST_SCAN: begin
				if (tab_val >= want_q) state_nx = pcs_pkg::ST_OUT;
			end
			pcs_pkg::ST_CAND: begin
				state_nx = (cand_q == pcs_pkg::TOP_31) ? pcs_pkg::ST_OUT : pcs_pkg::ST_CHECK;
			end
			pcs_pkg::ST_CHECK: begin
				state_nx = sq_over ? pcs_pkg::ST_OUT : pcs_pkg::ST_MODW;
			end
			pcs_pkg::ST_MODW: begin
				if (mod_done) begin
					priority if (mod_rem != 16'd0) state_nx = pcs_pkg::ST_CHECK;
					else if (cmd_q == pcs_pkg::CMD_TEST) state_nx = pcs_pkg::ST_OUT;
					else state_nx = pcs_pkg::ST_CAND;
				end
			end
			pcs_pkg::ST_OUT: state_nx = pcs_pkg::ST_IDLE;
			default: state_nx = pcs_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy             = (state_q != pcs_pkg::ST_IDLE);
		strobe           = (state_q == pcs_pkg::ST_OUT);
		mod_req.start    = (state_q == pcs_pkg::ST_CHECK) && !sq_over;
		mod_req.dividend = cand_q;
		mod_req.divisor  = d_q;
		result.answer    = ans_q;
		result.capped    = capped_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// datapath per state
	always_ff @(posedge clk) begin
		unique case (state_q)
			pcs_pkg::ST_IDLE: begin
				if (start) begin
					cmd_q    <= pcs_pkg::cmd_t'(item.command);
					val_q    <= item.value;
					capped_q <= 1'b0;
					ans_q    <= '0;
				end
			end
			pcs_pkg::ST_DISPATCH: begin
				cand_q <= val_q;
				d_q    <= 16'd3;
				want_q <= val_q;
				unique case (cmd_q)
					pcs_pkg::CMD_TEST: ans_q <= {30'd0, val_q == 31'd2};
					pcs_pkg::CMD_EXPAND: begin
						want_q <= dbl[30:0];
						if (cap_hit) begin
							ans_q    <= max_prime_q;
							capped_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			pcs_pkg::ST_LOOKUP: begin
				ans_q  <= pcs_pkg::MIN_CAPACITY;
				idx_q  <= '0;
				cand_q <= want_q | 31'd1;
			end
			pcs_pkg::ST_SCAN: begin
				ans_q <= tab_val;
				idx_q <= idx_q + 7'd1;
			end
			pcs_pkg::ST_CAND: begin
				ans_q <= max_prime_q;
				d_q   <= 16'd3;
			end
			pcs_pkg::ST_CHECK: begin
				ans_q <= (cmd_q == pcs_pkg::CMD_TEST) ? 31'd1 : cand_q;
			end
			pcs_pkg::ST_MODW: begin
				if (mod_done) begin
					d_q <= d_q + 16'd2;
					if (mod_rem == 16'd0) begin
						ans_q  <= '0;
						cand_q <= cand_q + 31'd2;
					end
				end
			end
			pcs_pkg::ST_OUT: ;
			default: ;
		endcase
	end

	pcs_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	`PCS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
	`PCS_ASSERT(a_strobe_once, strobe |=> !strobe && !busy, "result strobe not a single cycle")
	`PCS_ASSERT(a_done_in_wait, mod_done |-> (state_q == pcs_pkg::ST_MODW), "remainder done outside wait")
	`PCS_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !busy, "busy during reset")

endmodule

@@ rtl/pcs_mod_unit.sv @@
// Bit-serial restoring remainder: 31 steps, one dividend bit per cycle.
module pcs_mod_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  pcs_pkg::mod_req_t req,
	output logic             done,
	output logic [15:0]      rem
);

	logic [15:0] rem_q;
	logic [30:0] dvd_q;
	logic [15:0] dsr_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [16:0] trial;

	// shift in next dividend bit
	assign trial = {rem_q, dvd_q[30]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'd31;
		end else if (run_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (run_q) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= 16'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[15:0];
			end
			dvd_q <= {dvd_q[29:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
